/* rtl/dms_pkg.sv */
// Shared types and constants of the deconvolve and mode shuffle block.
package dms_pkg;

  localparam int MAX_GRID_DEF = 1024;
  localparam int NW           = 11;
  localparam int CW           = 10;
  localparam int IW           = 30;
  localparam int FRONT_STAGES = 4;
  localparam int FIFO_DEPTH   = 8;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic DIR_G2M = 1'b0;
  localparam logic DIR_M2G = 1'b1;

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_PREFACTOR = 3'd1;
  localparam logic [2:0] REG_MODES_X   = 3'd2;
  localparam logic [2:0] REG_MODES_Y   = 3'd3;
  localparam logic [2:0] REG_MODES_Z   = 3'd4;
  localparam logic [2:0] REG_GRID_X    = 3'd5;
  localparam logic [2:0] REG_GRID_Y    = 3'd6;
  localparam logic [2:0] REG_GRID_Z    = 3'd7;

  typedef struct packed {
    logic          dir;
    logic [31:0]   prefactor;
    logic [NW-1:0] mx;
    logic [NW-1:0] my;
    logic [NW-1:0] mz;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] nz;
  } cfg_t;

  typedef struct packed {
    logic [IW-1:0] lin;
    logic [31:0]   re;
    logic [31:0]   im;
    logic [31:0]   kx;
    logic [31:0]   ky;
    logic [31:0]   kz;
  } entry_t;

endpackage

/* rtl/dms_fifo.sv */
// Short queue between the classifying front and the arithmetic back.
module dms_fifo #(
  parameter int DEPTH = dms_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dms_pkg::entry_t push_data,
  input  logic            pop,
  output dms_pkg::entry_t pop_data,
  output logic            not_empty,
  output logic            room
);
  localparam int PW  = $clog2(DEPTH);
  localparam int CTW = $clog2(DEPTH + 1);

  dms_pkg::entry_t store [0:DEPTH-1];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CTW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

  assign pop_data  = store[rd_ptr];
  assign not_empty = (count != '0);
  assign room      = (32'(count) < DEPTH - dms_pkg::FRONT_STAGES);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> 32'(count) < DEPTH) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count slip");

endmodule

/* rtl/dms_front.sv */
// Front: accepts items, writes kernel tables, classifies samples, reads kernels.
module dms_front #(
  parameter int MAX_GRID = dms_pkg::MAX_GRID_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dms_pkg::cfg_t          cfg,
  input  logic                   room,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [1:0]             table_select,
  input  logic [dms_pkg::CW-1:0] coord_x,
  input  logic [dms_pkg::CW-1:0] coord_y,
  input  logic [dms_pkg::CW-1:0] coord_z,
  input  logic signed [31:0]     value_re,
  input  logic signed [31:0]     value_im,
  input  logic [31:0]            kernel_value,
  output logic                   push,
  output dms_pkg::entry_t        push_data
);
  localparam int NW     = dms_pkg::NW;
  localparam int CW     = dms_pkg::CW;
  localparam int IW     = dms_pkg::IW;
  localparam int TDEPTH = MAX_GRID / 2 + 1;
  localparam int AW     = $clog2(TDEPTH);
  localparam int TW     = 2 * NW + 1;

  typedef struct packed {
    logic          ok;
    logic [NW-1:0] idx;
    logic [AW-1:0] f;
  } axis_t;

  function automatic axis_t classify(input logic dir, input logic [CW-1:0] c,
                                     input logic [NW-1:0] m, input logic [NW-1:0] n);
    axis_t         a;
    logic [NW-1:0] cc;
    logic [NW-1:0] k0;
    logic [NW-1:0] f;
    a  = '0;
    cc = NW'(c);
    k0 = m >> 1;
    f  = '0;
    if (dir == dms_pkg::DIR_G2M) begin
      if (cc < n) begin
        if (m != '0 && cc <= ((m - 1'b1) >> 1)) begin
          a.ok  = 1'b1;
          a.idx = k0 + cc;
          f     = cc;
        end else if (k0 != '0 && cc >= n - k0) begin
          a.ok  = 1'b1;
          f     = n - cc;
          a.idx = k0 - f;
        end
      end
    end else begin
      if (cc < m) begin
        a.ok = 1'b1;
        if (cc >= k0) begin
          f     = cc - k0;
          a.idx = f;
        end else begin
          f     = k0 - cc;
          a.idx = n - f;
        end
      end
    end
    a.f = (32'(f) >= TDEPTH) ? AW'(TDEPTH - 1) : AW'(f);
    return a;
  endfunction

  logic en;
  assign en       = room;
  assign in_stall = !en;

  // stage 1: input register
  logic            s1_valid;
  logic            s1_op;
  logic [1:0]      s1_sel;
  logic [CW-1:0]   s1_cx, s1_cy, s1_cz;
  logic [31:0]     s1_re, s1_im, s1_kv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= opcode;
      s1_sel <= table_select;
      s1_cx  <= coord_x;
      s1_cy  <= coord_y;
      s1_cz  <= coord_z;
      s1_re  <= value_re;
      s1_im  <= value_im;
      s1_kv  <= kernel_value;
    end
  end

  // stage 2: classification
  axis_t ax, ay, az;
  assign ax = classify(cfg.dir, s1_cx, cfg.mx, cfg.nx);
  assign ay = classify(cfg.dir, s1_cy, cfg.my, cfg.ny);
  assign az = classify(cfg.dir, s1_cz, cfg.mz, cfg.nz);

  logic            s2_valid;
  logic            s2_load;
  logic [1:0]      s2_sel;
  logic [AW-1:0]   s2_addr;
  logic [31:0]     s2_kv, s2_re, s2_im;
  logic [NW-1:0]   s2_ix, s2_iy, s2_iz, s2_fa, s2_fb;
  logic [AW-1:0]   s2_fx, s2_fy, s2_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_load  <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_op == dms_pkg::OP_SAMPLE && ax.ok && ay.ok && az.ok;
      s2_load  <= s1_valid && s1_op == dms_pkg::OP_LOAD && (32'(s1_cx) < TDEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sel  <= s1_sel;
      s2_addr <= AW'(s1_cx);
      s2_kv   <= s1_kv;
      s2_re   <= s1_re;
      s2_im   <= s1_im;
      s2_ix   <= ax.idx;
      s2_iy   <= ay.idx;
      s2_iz   <= az.idx;
      s2_fx   <= ax.f;
      s2_fy   <= ay.f;
      s2_fz   <= az.f;
      s2_fa   <= (cfg.dir == dms_pkg::DIR_G2M) ? cfg.mx : cfg.nx;
      s2_fb   <= (cfg.dir == dms_pkg::DIR_G2M) ? cfg.my : cfg.ny;
    end
  end

  // stage 3: kernel tables, written and read at the same stage to keep order
  logic [31:0] mem_x [0:TDEPTH-1];
  logic [31:0] mem_y [0:TDEPTH-1];
  logic [31:0] mem_z [0:TDEPTH-1];
  logic [31:0] s3_kx, s3_ky, s3_kz;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_load && s2_sel == dms_pkg::SEL_X) mem_x[s2_addr] <= s2_kv;
      if (s2_load && s2_sel == dms_pkg::SEL_Y) mem_y[s2_addr] <= s2_kv;
      if (s2_load && s2_sel == dms_pkg::SEL_Z) mem_z[s2_addr] <= s2_kv;
      s3_kx <= mem_x[s2_fx];
      s3_ky <= mem_y[s2_fy];
      s3_kz <= mem_z[s2_fz];
    end
  end

  logic [TW-1:0]   yz_prod;
  logic            s3_valid;
  logic [TW-1:0]   s3_t;
  logic [NW-1:0]   s3_ix, s3_fa;
  logic [31:0]     s3_re, s3_im;

  assign yz_prod = TW'(s2_fb) * TW'(s2_iz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t  <= yz_prod + TW'(s2_iy);
      s3_ix <= s2_ix;
      s3_fa <= s2_fa;
      s3_re <= s2_re;
      s3_im <= s2_im;
    end
  end

  // stage 4: linear index
  logic [NW+TW-1:0] x_prod;
  logic [NW+TW:0]   lin_full;
  logic             s4_valid;

  assign x_prod   = (NW + TW)'(s3_fa) * (NW + TW)'(s3_t);
  assign lin_full = {1'b0, x_prod} + (NW + TW + 1)'(s3_ix);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      push_data.lin <= lin_full[IW-1:0];
      push_data.re  <= s3_re;
      push_data.im  <= s3_im;
      push_data.kx  <= s3_kx;
      push_data.ky  <= s3_ky;
      push_data.kz  <= s3_kz;
    end
  end

  assign push = s4_valid && en;

endmodule

/* rtl/dms_div.sv */
// Pipelined gain divider: floor(g * 2^24 / k), one quotient bit per stage.
module dms_div #(
  parameter int PW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [31:0]   in_g,
  input  logic [31:0]   in_k,
  input  logic          in_sat,
  input  logic [PW-1:0] in_pl,
  output logic          out_valid,
  output logic [31:0]   out_q,
  output logic          out_sat,
  output logic [PW-1:0] out_pl
);
  localparam int NS = 32;

  logic          v   [0:NS];
  logic [31:0]   r   [0:NS];
  logic [31:0]   f   [0:NS];
  logic [31:0]   q   [0:NS];
  logic [31:0]   k   [0:NS];
  logic          ovf [0:NS];
  logic          sat [0:NS];
  logic [PW-1:0] pl  [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  // zero divisor or quotient beyond 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= {8'd0, in_g[31:8]};
      f[0]   <= {in_g[7:0], 24'd0};
      q[0]   <= '0;
      k[0]   <= in_k;
      ovf[0] <= (in_k == '0) || ({8'd0, in_g} >= {in_k, 8'd0});
      sat[0] <= in_sat;
      pl[0]  <= in_pl;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_stage
    logic [32:0] t;
    logic [32:0] d;
    logic        ge;
    assign t  = {r[i-1], f[i-1][31]};
    assign d  = t - {1'b0, k[i-1]};
    assign ge = (t >= {1'b0, k[i-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[i]   <= ge ? d[31:0] : t[31:0];
        f[i]   <= {f[i-1][30:0], 1'b0};
        q[i]   <= {q[i-1][30:0], ge};
        k[i]   <= k[i-1];
        ovf[i] <= ovf[i-1];
        sat[i] <= sat[i-1];
        pl[i]  <= pl[i-1];
      end
    end
  end

  assign out_valid = v[NS];
  assign out_q     = ovf[NS] ? 32'hFFFF_FFFF : q[NS];
  assign out_sat   = ovf[NS] || sat[NS];
  assign out_pl    = pl[NS];

endmodule

/* rtl/dms_back.sv */
// Back: three chained gain divisions, complex scaling, clipping, output register.
module dms_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            prefactor,
  input  logic                   not_empty,
  input  dms_pkg::entry_t        pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [dms_pkg::IW-1:0] target_index,
  output logic signed [31:0]     out_re,
  output logic signed [31:0]     out_im,
  output logic                   saturated
);
  localparam int IW = dms_pkg::IW;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clip_t;

  function automatic clip_t clip(input logic [63:0] p, input logic neg);
    clip_t       c;
    logic [47:0] qq;
    qq    = p[63:16];
    c.sat = 1'b0;
    if (neg) begin
      if (qq > 48'h0000_8000_0000) begin
        c.sat = 1'b1;
        qq    = 48'h0000_8000_0000;
      end
      c.val = 32'd0 - qq[31:0];
    end else begin
      if (qq > 48'h0000_7FFF_FFFF) begin
        c.sat = 1'b1;
        qq    = 48'h0000_7FFF_FFFF;
      end
      c.val = qq[31:0];
    end
    return c;
  endfunction

  logic en;
  assign en  = !out_valid || !out_stall;
  assign pop = en && not_empty;

  localparam int PZ = 3 * 32 + IW + 32;
  localparam int PY = 4 * 32 + IW - 32;
  localparam int PX = IW + 64;

  logic          vz, vy, vx;
  logic [31:0]   gz, gy, gx;
  logic          sz, sy, sx;
  logic [PZ-1:0] plz;
  logic [PY-1:0] ply;
  logic [PX-1:0] plx;

  dms_div #(.PW(PZ)) u_div_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pop), .in_g(prefactor), .in_k(pop_data.kz), .in_sat(1'b0),
    .in_pl({pop_data.kx, pop_data.ky, pop_data.lin, pop_data.re, pop_data.im}),
    .out_valid(vz), .out_q(gz), .out_sat(sz), .out_pl(plz)
  );

  dms_div #(.PW(PY)) u_div_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vz), .in_g(gz), .in_k(plz[PZ-33:PZ-64]), .in_sat(sz),
    .in_pl({plz[PZ-1:PZ-32], plz[PX-1:0]}),
    .out_valid(vy), .out_q(gy), .out_sat(sy), .out_pl(ply)
  );

  dms_div #(.PW(PX)) u_div_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vy), .in_g(gy), .in_k(ply[PY-1:PY-32]), .in_sat(sy),
    .in_pl(ply[PX-1:0]),
    .out_valid(vx), .out_q(gx), .out_sat(sx), .out_pl(plx)
  );

  logic [31:0] vre, vim, mag_re, mag_im;
  logic [63:0] p_re_next, p_im_next;
  assign vre       = plx[63:32];
  assign vim       = plx[31:0];
  assign mag_re    = vre[31] ? (~vre + 32'd1) : vre;
  assign mag_im    = vim[31] ? (~vim + 32'd1) : vim;
  assign p_re_next = {32'd0, mag_re} * {32'd0, gx};
  assign p_im_next = {32'd0, mag_im} * {32'd0, gx};

  logic          m_valid;
  logic [63:0]   p_re, p_im;
  logic          m_neg_re, m_neg_im, m_sat;
  logic [IW-1:0] m_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_re     <= p_re_next;
      p_im     <= p_im_next;
      m_neg_re <= vre[31];
      m_neg_im <= vim[31];
      m_sat    <= sx;
      m_lin    <= plx[PX-1:64];
    end
  end

  clip_t c_re, c_im;
  assign c_re = clip(p_re, m_neg_re);
  assign c_im = clip(p_im, m_neg_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      target_index <= m_lin;
      out_re       <= c_re.val;
      out_im       <= c_im.val;
      saturated    <= m_sat || c_re.sat || c_im.sat;
    end
  end

endmodule

/* rtl/deconvolve_mode_shuffle_3d_core.sv */
// Top level: configuration registers, front, queue and back of the deconvolve stage.
// Throughput: one item per cycle while neither in_stall nor out_stall holds the flow;
// the three gain divisions are 33-stage pipelines.
// Loads and dropped samples give no result; loads reach the tables from the stage 2 registers.
// Reset: synchronous, clears all valid flags and queue pointers and loads register defaults;
// kernel tables are not cleared and hold undefined data until written.
module deconvolve_mode_shuffle_3d_core #(
  parameter int MAX_GRID = dms_pkg::MAX_GRID_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [1:0]             table_select,
  input  logic [dms_pkg::CW-1:0] coord_x,
  input  logic [dms_pkg::CW-1:0] coord_y,
  input  logic [dms_pkg::CW-1:0] coord_z,
  input  logic signed [31:0]     value_re,
  input  logic signed [31:0]     value_im,
  input  logic [31:0]            kernel_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [dms_pkg::IW-1:0] target_index,
  output logic signed [31:0]     out_re,
  output logic signed [31:0]     out_im,
  output logic                   saturated
);
  localparam int NW = dms_pkg::NW;

  logic          direction;
  logic [31:0]   prefactor;
  logic [NW-1:0] modes_x, modes_y, modes_z;
  logic [NW-1:0] grid_x, grid_y, grid_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= dms_pkg::DIR_G2M;
      prefactor <= 32'h0001_0000;
      modes_x   <= '0;
      modes_y   <= '0;
      modes_z   <= '0;
      grid_x    <= NW'(2);
      grid_y    <= NW'(2);
      grid_z    <= NW'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dms_pkg::REG_DIRECTION: direction <= cfg_data[0];
        dms_pkg::REG_PREFACTOR: prefactor <= cfg_data;
        dms_pkg::REG_MODES_X:   modes_x   <= cfg_data[NW-1:0];
        dms_pkg::REG_MODES_Y:   modes_y   <= cfg_data[NW-1:0];
        dms_pkg::REG_MODES_Z:   modes_z   <= cfg_data[NW-1:0];
        dms_pkg::REG_GRID_X:    grid_x    <= cfg_data[NW-1:0];
        dms_pkg::REG_GRID_Y:    grid_y    <= cfg_data[NW-1:0];
        dms_pkg::REG_GRID_Z:    grid_z    <= cfg_data[NW-1:0];
      endcase
    end
  end

  function automatic logic [NW-1:0] eff_grid(input logic [NW-1:0] n);
    logic [NW-1:0] e;
    if (n < NW'(2)) e = NW'(2);
    else if (32'(n) > MAX_GRID) e = NW'(MAX_GRID);
    else e = n;
    return e;
  endfunction

  dms_pkg::cfg_t cfg;
  always_comb begin
    cfg.dir       = direction;
    cfg.prefactor = prefactor;
    cfg.nx        = eff_grid(grid_x);
    cfg.ny        = eff_grid(grid_y);
    cfg.nz        = eff_grid(grid_z);
    cfg.mx        = (modes_x > cfg.nx) ? cfg.nx : modes_x;
    cfg.my        = (modes_y > cfg.ny) ? cfg.ny : modes_y;
    cfg.mz        = (modes_z > cfg.nz) ? cfg.nz : modes_z;
  end

  logic            room, push, pop, not_empty;
  dms_pkg::entry_t push_data, pop_data;

  dms_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .room(room),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .table_select(table_select),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .value_re(value_re), .value_im(value_im), .kernel_value(kernel_value),
    .push(push), .push_data(push_data)
  );

  dms_fifo #(.DEPTH(dms_pkg::FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .not_empty(not_empty), .room(room)
  );

  dms_back u_back (
    .clk(clk), .rst(rst), .prefactor(cfg.prefactor),
    .not_empty(not_empty), .pop_data(pop_data), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .target_index(target_index), .out_re(out_re), .out_im(out_im),
    .saturated(saturated)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the 3D deconvolve and mode shuffle core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dms_pkg::*;

  localparam int TBL_DEPTH = MAX_GRID_DEF / 2 + 1;
  localparam int DRAIN_PAD = 130;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 115;

  typedef struct {
    logic        op;
    logic [1:0]  sel;
    logic [9:0]  cx, cy, cz;
    logic [31:0] re, im, kv;
  } item_t;

  typedef struct {
    logic [IW-1:0] idx;
    logic [31:0]   re, im;
    logic          sat;
  } res_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  ridx;
    logic [31:0] data;
    item_t       it;
    bit          typed;
    bit          has_res;
    res_t        want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic opcode;
  logic [1:0] table_select;
  logic [CW-1:0] coord_x, coord_y, coord_z;
  logic signed [31:0] value_re, value_im;
  logic [31:0] kernel_value;
  logic out_valid, out_stall;
  logic [IW-1:0] target_index;
  logic signed [31:0] out_re, out_im;
  logic saturated;

  deconvolve_mode_shuffle_3d_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow configuration and kernel tables
  logic        sh_dir;
  logic [31:0] sh_gain;
  logic [10:0] sh_m [3];
  logic [10:0] sh_n [3];
  logic [31:0] ktab [3][TBL_DEPTH];
  bit          planned [3][TBL_DEPTH];

  res_t expected_q [$];
  row_t rows [$];
  int   fails = 0;
  int   quiet = 0;
  int   sent = 0;
  int   in_calm = 0, out_calm = 0;
  bit   hold_req = 0;

  // typed expectation travelling with the item being offered
  bit   cur_typed, cur_has;
  res_t cur_want;

  function automatic int unsigned eff_grid(logic [10:0] v);
    if (v < 2) return 2;
    if (v > MAX_GRID_DEF) return MAX_GRID_DEF;
    return v;
  endfunction

  function automatic int unsigned eff_modes(logic [10:0] m, int unsigned n);
    return (m > n) ? n : m;
  endfunction

  function automatic bit axis_map(logic d, int unsigned c, int unsigned m, int unsigned n,
                                  output int unsigned idx, output int unsigned f);
    int unsigned k0;
    k0 = m / 2;
    if (d == DIR_G2M) begin
      if (c >= n) return 0;
      if (m > 0 && c <= (m - 1) / 2) begin
        idx = k0 + c;
        f = c;
        return 1;
      end
      if (k0 > 0 && c >= n - k0) begin
        f = n - c;
        idx = k0 - f;
        return 1;
      end
      return 0;
    end
    if (c >= m) return 0;
    if (c >= k0) begin
      idx = c - k0;
      f = c - k0;
    end else begin
      f = k0 - c;
      idx = n - f;
    end
    return 1;
  endfunction

  function automatic logic [31:0] gain_div(logic [31:0] g, logic [31:0] k, inout logic sat);
    longint unsigned q;
    if (k == 0) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    q = g;
    q = (q << 24) / k;
    if (q > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic logic [31:0] apply_gain(logic [31:0] v, logic [31:0] g, inout logic sat);
    longint unsigned mag, q;
    logic [31:0] neg_v;
    neg_v = -v;
    mag = v[31] ? neg_v : v;
    q = (mag * g) >> 16;
    if (v[31]) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        q = 64'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      q = 64'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // map one item through the shadow state; returns 1 if it yields a result
  function automatic bit deconvolve(item_t it, output res_t r);
    int unsigned n [3], m [3], ix [3], f [3];
    int unsigned c [3];
    longint unsigned lin;
    logic [31:0] g;
    logic sat;
    c[0] = it.cx;
    c[1] = it.cy;
    c[2] = it.cz;
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      n[a] = eff_grid(sh_n[a]);
      m[a] = eff_modes(sh_m[a], n[a]);
      if (!axis_map(sh_dir, c[a], m[a], n[a], ix[a], f[a])) return 0;
      if (f[a] >= TBL_DEPTH) f[a] = TBL_DEPTH - 1;
    end
    if (sh_dir == DIR_G2M)
      lin = longint'(ix[0]) + longint'(m[0]) * (longint'(ix[1]) + longint'(m[1]) * ix[2]);
    else
      lin = longint'(ix[0]) + longint'(n[0]) * (longint'(ix[1]) + longint'(n[1]) * ix[2]);
    g = sh_gain;
    g = gain_div(g, ktab[2][f[2]], sat);
    g = gain_div(g, ktab[1][f[1]], sat);
    g = gain_div(g, ktab[0][f[0]], sat);
    r.idx = lin[IW-1:0];
    r.re = apply_gain(it.re, g, sat);
    r.im = apply_gain(it.im, g, sat);
    r.sat = sat;
    return 1;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [31:0] rand_kernel();
    case ($urandom_range(0, 15))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1 << 22, 1 << 26);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1 << 18) - (1 << 17);
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t mk_sample(int unsigned x, int unsigned y, int unsigned z,
                                      logic [31:0] re, logic [31:0] im);
    item_t it;
    it = '{op: OP_SAMPLE, sel: $urandom_range(0, 3), cx: x, cy: y, cz: z,
           re: re, im: im, kv: $urandom};
    return it;
  endfunction

  function automatic item_t mk_load(logic [1:0] sel, int unsigned idx, logic [31:0] kv);
    item_t it;
    it = '{op: OP_LOAD, sel: sel, cx: idx, cy: $urandom_range(0, 1023),
           cz: $urandom_range(0, 1023), re: $urandom, im: $urandom, kv: kv};
    return it;
  endfunction

  task automatic offer(item_t it, bit typed, bit has, res_t w);
    int n;
    n = draw_wait(in_calm);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    opcode <= it.op;
    table_select <= it.sel;
    coord_x <= it.cx;
    coord_y <= it.cy;
    coord_z <= it.cz;
    value_re <= it.re;
    value_im <= it.im;
    kernel_value <= it.kv;
    cur_typed <= typed;
    cur_has <= has;
    cur_want <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // loads any kernel entry a kept sample would read before the sample itself
  task automatic issue(item_t it, bit typed, bit has, res_t w);
    int unsigned c [3], n, m, idx, f;
    res_t none;
    none = '{default: '0};
    c[0] = it.cx;
    c[1] = it.cy;
    c[2] = it.cz;
    if (it.op == OP_SAMPLE) begin
      for (int a = 0; a < 3; a++) begin
        n = eff_grid(sh_n[a]);
        m = eff_modes(sh_m[a], n);
        if (axis_map(sh_dir, c[a], m, n, idx, f)) begin
          if (f >= TBL_DEPTH) f = TBL_DEPTH - 1;
          if (!planned[a][f]) begin
            planned[a][f] = 1;
            offer(mk_load(a, f, rand_kernel()), 0, 0, none);
          end
        end
      end
    end else if (it.sel <= SEL_Z && it.cx < TBL_DEPTH) begin
      planned[it.sel][it.cx] = 1;
    end
    offer(it, typed, has, w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] r, logic [31:0] d);
    cfg_index <= r;
    cfg_data <= d;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_DIRECTION: sh_dir = d[0];
      REG_PREFACTOR: sh_gain = d;
      REG_MODES_X: sh_m[0] = d[10:0];
      REG_MODES_Y: sh_m[1] = d[10:0];
      REG_MODES_Z: sh_m[2] = d[10:0];
      REG_GRID_X: sh_n[0] = d[10:0];
      REG_GRID_Y: sh_n[1] = d[10:0];
      default: sh_n[2] = d[10:0];
    endcase
    @(posedge clk);
  endtask

  function automatic void add_cfg(logic [2:0] r, logic [31:0] d);
    row_t row;
    row = '{default: '0};
    row.is_cfg = 1;
    row.ridx = r;
    row.data = d;
    rows.push_back(row);
  endfunction

  function automatic void add_item(item_t it);
    row_t row;
    row = '{default: '0};
    row.it = it;
    rows.push_back(row);
  endfunction

  function automatic void add_typed(item_t it, bit has, logic [IW-1:0] idx,
                                    logic [31:0] re, logic [31:0] im, logic sat);
    row_t row;
    row = '{default: '0};
    row.it = it;
    row.typed = 1;
    row.has_res = has;
    row.want = '{idx: idx, re: re, im: im, sat: sat};
    rows.push_back(row);
  endfunction

  function automatic logic [10:0] rand_grid();
    case ($urandom_range(0, 9))
      0: return MAX_GRID_DEF;
      1: return $urandom_range(0, 2047);
      2: return 2 * $urandom_range(1, MAX_GRID_DEF / 2);
      default: return 2 * $urandom_range(1, 16);
    endcase
  endfunction

  function automatic logic [10:0] rand_modes(logic [10:0] g);
    int unsigned n;
    n = eff_grid(g);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(0, 2047);
      2, 3: return n;
      default: return $urandom_range(1, n);
    endcase
  endfunction

  function automatic logic [31:0] rand_prefactor();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(1 << 14, 1 << 18);
    endcase
  endfunction

  function automatic int unsigned pick_coord(int a);
    int unsigned n, m, k0;
    n = eff_grid(sh_n[a]);
    m = eff_modes(sh_m[a], n);
    k0 = m / 2;
    if (m == 0) return $urandom_range(0, 1023);
    if (sh_dir == DIR_M2G) return $urandom_range(0, m - 1);
    if (k0 > 0 && $urandom_range(0, 1)) return n - $urandom_range(1, k0);
    return $urandom_range(0, (m - 1) / 2);
  endfunction

  // input acceptance: update tables, queue the expected result
  always @(posedge clk) begin
    item_t it;
    res_t r;
    if (!rst && in_valid && !in_stall) begin
      it = '{op: opcode, sel: table_select, cx: coord_x, cy: coord_y, cz: coord_z,
             re: value_re, im: value_im, kv: kernel_value};
      if (cur_typed) begin
        if (cur_has) expected_q.push_back(cur_want);
      end else if (it.op == OP_LOAD) begin
        if (it.sel <= SEL_Z && it.cx < TBL_DEPTH) ktab[it.sel][it.cx] = it.kv;
      end else if (deconvolve(it, r)) begin
        expected_q.push_back(r);
      end
      if (cur_typed && it.op == OP_LOAD && it.sel <= SEL_Z && it.cx < TBL_DEPTH)
        ktab[it.sel][it.cx] = it.kv;
    end
  end

  always @(posedge clk) begin
    res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: index %0d", target_index);
        fails++;
      end else begin
        w = expected_q.pop_front();
        if (target_index !== w.idx) begin
          $error("target_index: expected %0d, got %0d", w.idx, target_index);
          fails++;
        end
        if (out_re !== w.re) begin
          $error("out_re: expected %h, got %h", w.re, out_re);
          fails++;
        end
        if (out_im !== w.im) begin
          $error("out_im: expected %h, got %h", w.im, out_im);
          fails++;
        end
        if (saturated !== w.sat) begin
          $error("saturated: expected %b, got %b", w.sat, saturated);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = draw_wait(out_calm);
      if (hold_req) begin
        hold_req = 0;
        n = 400;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    item_t it;
    int unsigned r;
    int budget;
    res_t none;
    none = '{default: '0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    opcode = OP_LOAD;
    table_select = SEL_X;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    value_re = '0;
    value_im = '0;
    kernel_value = '0;
    cur_typed = 0;
    cur_has = 0;
    cur_want = none;
    sh_dir = DIR_G2M;
    sh_gain = 32'd65536;
    foreach (sh_m[a]) begin
      sh_m[a] = 0;
      sh_n[a] = 2;
    end

    // no modes kept after reset: every sample is dropped
    add_typed(mk_sample(0, 0, 0, 32'h0001_0000, 32'h0001_0000), 0, 0, 0, 0, 0);
    add_cfg(REG_MODES_X, 4);
    add_cfg(REG_MODES_Y, 4);
    add_cfg(REG_MODES_Z, 4);
    add_cfg(REG_GRID_X, 8);
    add_cfg(REG_GRID_Y, 8);
    add_cfg(REG_GRID_Z, 8);
    add_item(mk_load(SEL_X, 0, 32'h0100_0000));
    add_item(mk_load(SEL_Y, 0, 32'h0100_0000));
    add_item(mk_load(SEL_Z, 0, 32'h0100_0000));
    add_item(mk_load(SEL_X, 1, 32'h0100_0000));
    add_item(mk_load(SEL_Y, 1, 32'h0100_0000));
    add_item(mk_load(SEL_Z, 1, 32'h0000_0000));
    // loads that must be ignored
    add_item(mk_load(2'd3, 0, 32'h0000_0000));
    add_item(mk_load(SEL_X, 1023, 32'h0000_0000));
    add_item(mk_load(SEL_X, TBL_DEPTH, 32'h0000_0000));
    add_typed(mk_sample(0, 0, 0, 32'h0001_0000, 32'hFFFF_0000), 1, 42,
              32'h0001_0000, 32'hFFFF_0000, 0);
    add_typed(mk_sample(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000), 1, 42,
              32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_typed(mk_sample(7, 0, 0, 32'h0, 32'h0), 1, 41, 32'h0, 32'h0, 0);
    // zero kernel entry: gain saturates, value clips
    add_typed(mk_sample(0, 0, 1, 32'h0001_0000, 32'h0), 1, 58, 32'h7FFF_FFFF, 32'h0, 1);
    add_typed(mk_sample(8, 0, 0, 32'h0001_0000, 32'h0), 0, 0, 0, 0, 0);
    add_typed(mk_sample(4, 0, 0, 32'h0001_0000, 32'h0), 0, 0, 0, 0, 0);
    add_cfg(REG_PREFACTOR, 32'hFFFF_FFFF);
    add_typed(mk_sample(0, 0, 0, 32'h1, 32'hFFFF_FFFF), 1, 42, 32'h0000_FFFF, 32'hFFFF_0001, 0);
    add_cfg(REG_PREFACTOR, 32'h0);
    add_typed(mk_sample(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000), 1, 42, 32'h0, 32'h0, 0);
    add_cfg(REG_DIRECTION, DIR_M2G);
    add_cfg(REG_PREFACTOR, 32'd65536);
    add_item(mk_sample(3, 0, 2, $urandom, $urandom));
    add_typed(mk_sample(4, 0, 0, 32'h0001_0000, 32'h0), 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].ridx, rows[i].data);
      end else begin
        issue(rows[i].it, rows[i].typed, rows[i].has_res, rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_DIRECTION, $urandom_range(0, 1));
      write_reg(REG_PREFACTOR, rand_prefactor());
      if (p == 0) begin
        write_reg(REG_GRID_X, MAX_GRID_DEF);
        write_reg(REG_GRID_Y, MAX_GRID_DEF);
        write_reg(REG_GRID_Z, MAX_GRID_DEF);
        write_reg(REG_MODES_X, MAX_GRID_DEF);
        write_reg(REG_MODES_Y, MAX_GRID_DEF);
        write_reg(REG_MODES_Z, MAX_GRID_DEF);
      end else begin
        write_reg(REG_GRID_X, rand_grid());
        write_reg(REG_GRID_Y, rand_grid());
        write_reg(REG_GRID_Z, rand_grid());
        write_reg(REG_MODES_X, rand_modes(sh_n[0]));
        write_reg(REG_MODES_Y, rand_modes(sh_n[1]));
        write_reg(REG_MODES_Z, rand_modes(sh_n[2]));
      end
      if (p == 2) hold_req = 1;
      budget = sent + PHASE_ITEMS;
      while (sent < budget) begin
        r = $urandom_range(0, 99);
        if (r < 75)
          it = mk_sample(pick_coord(0), pick_coord(1), pick_coord(2), rand_value(), rand_value());
        else if (r < 85)
          it = mk_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom, $urandom);
        else if (r < 95)
          it = mk_load($urandom_range(0, 2), $urandom_range(0, TBL_DEPTH - 1), rand_kernel());
        else if (r < 98)
          it = mk_load(2'd3, $urandom_range(0, 1023), $urandom);
        else
          it = mk_load($urandom_range(0, 2), $urandom_range(TBL_DEPTH, 1023), $urandom);
        issue(it, 0, 0, none);
      end
    end

    drain();
    if (fails == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
